FILE: rtl/brwt_pkg.sv
// Package for the block receive window tracker.
// Widths, status codes, register indexes, state and ALU types.
// No dependencies.
package brwt_pkg;

  localparam int MAX_BLOCKS_DEF = 4096;

  localparam int AW     = 32;  // shared ALU width
  localparam int N_W    = 29;  // block count / last index before range check
  localparam int EP_W   = 8;   // epoch tag width in the receive map
  localparam int FID_W  = 31;
  localparam int FSZ_W  = 28;
  localparam int LOG_W  = 5;
  localparam int WIN_W  = 13;
  localparam int IDX_W  = 16;
  localparam int SZ_W   = 17;
  localparam int BS_W   = 17;
  localparam int REM_W  = 13;
  localparam int OFF_W  = 28;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;
  localparam int MAX_LOG2 = 16;

  localparam logic [1:0] REG_FILE_ID   = 2'd0;
  localparam logic [1:0] REG_FILE_SIZE = 2'd1;
  localparam logic [1:0] REG_BLK_LOG2  = 2'd2;
  localparam logic [1:0] REG_WINDOW    = 2'd3;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ACCEPTED   = 3'd1,
    ST_DUP        = 3'd2,
    ST_WRONG_FILE = 3'd3,
    ST_UNEXPECTED = 3'd4,
    ST_RANGE      = 3'd5,
    ST_WRITE_ERR  = 3'd6,
    ST_BAD_CFG    = 3'd7
  } status_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t         op;
    logic [AW-1:0]   a;
    logic [AW-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [AW-1:0] res;
    logic          zero;
    logic          neg;   // borrow on subtract
  } alu_rsp_t;

  typedef struct packed {
    logic [FID_W-1:0] file_id;
    logic [FSZ_W-1:0] file_size;
    logic [LOG_W-1:0] block_size_log2;
    logic [WIN_W-1:0] request_window;
  } cfg_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_CNT,
    S_MAXC,
    S_WIN,
    S_WPI,
    S_FID,
    S_PAY,
    S_LAST,
    S_IDX,
    S_REM,
    S_CLM,
    S_WPC,
    S_DECB,
    S_DECW,
    S_MINW,
    S_ADDWP,
    S_FIN,
    S_EMIT
  } seq_state_t;

endpackage

FILE: rtl/brwt_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module brwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/brwt_alu.sv
// Shared add/subtract unit with zero and borrow flags.
// Depends on brwt_pkg.
module brwt_alu import brwt_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [AW:0] sum;

  always_comb begin
    case (req.op)
      ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: sum = {1'b0, req.a} + {1'b0, ~req.b} + (AW+1)'(1);
      default: sum = {1'b0, req.a} + {1'b0, req.b};
    endcase
    rsp.res  = sum[AW-1:0];
    rsp.zero = (sum[AW-1:0] == '0);
    rsp.neg  = (req.op == ALU_SUB) ? !sum[AW] : 1'b0;
  end

endmodule

FILE: rtl/brwt_seq.sv
// Sequencer: walks each item through the shared ALU, keeps the transfer
// state and the result register. Depends on brwt_pkg.
module brwt_seq import brwt_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [FID_W-1:0]              arrived_file_id,
  input  logic [IDX_W-1:0]              block_index,
  input  logic [SZ_W-1:0]               claimed_size,
  input  logic [SZ_W-1:0]               payload_bytes,
  input  logic                          write_ok,
  output logic                          out_valid,
  input  logic                          out_stall,
  output status_t                       status,
  output logic                          request_more,
  output logic [REM_W-1:0]              remaining,
  output logic [OFF_W-1:0]              write_offset,
  output alu_req_t                      alu_req,
  input  alu_rsp_t                      alu_rsp,
  output logic                          ram_we,
  output logic [$clog2(MAX_BLOCKS)-1:0] ram_waddr,
  output logic [EP_W-1:0]               ram_wdata,
  output logic [$clog2(MAX_BLOCKS)-1:0] ram_raddr,
  input  logic [EP_W-1:0]               ram_rdata
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int BW = $clog2(MAX_BLOCKS + 1);

  seq_state_t state, state_next;

  logic             item_mode;
  logic [FID_W-1:0] item_fid;
  logic [IDX_W-1:0] item_idx;
  logic [SZ_W-1:0]  item_claimed;
  logic [SZ_W-1:0]  item_payload;
  logic             item_wok;

  logic [N_W-1:0]   n_r;
  logic [N_W-1:0]   last_r;
  logic             lt_r;
  logic             eq_r;
  logic [AW-1:0]    rem_r;

  logic [BW-1:0]    blocks_left;
  logic [BW-1:0]    window_left;
  logic [IW-1:0]    window_position;
  logic             active;
  logic [EP_W-1:0]  epoch;
  logic             pend;
  logic [IW-1:0]    clear_addr;

  status_t          res_status;
  logic             res_req;
  logic [OFF_W-1:0] off_r;

  logic [BS_W-1:0]  bs;
  logic [BS_W-1:0]  bs_m1;
  logic             static_bad;
  logic             accept_in;
  logic             out_free;
  logic             wanted;
  logic             clear_last;
  logic [OFF_W-1:0] off_calc;

  assign bs         = BS_W'(1) << cfg.block_size_log2;
  assign bs_m1      = bs - BS_W'(1);
  assign static_bad = (cfg.file_id == '0) || (cfg.file_size == '0) ||
                      (cfg.block_size_log2 == '0) ||
                      (cfg.block_size_log2 > LOG_W'(MAX_LOG2));
  assign in_stall   = (state != S_IDLE);
  assign accept_in  = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign clear_last = (clear_addr == IW'(MAX_BLOCKS - 1));
  assign off_calc   = OFF_W'(AW'(item_idx) << cfg.block_size_log2);
  // in S_WPC: index within marked windows and not yet received this epoch
  assign wanted     = !alu_rsp.neg && (ram_rdata != epoch);
  assign ram_raddr  = item_idx[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_req    = '{op: ALU_SUB, a: '0, b: '0};
    ram_we     = 1'b0;
    ram_waddr  = item_idx[IW-1:0];
    ram_wdata  = epoch;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_addr;
        ram_wdata = '0;
        if (clear_last) state_next = pend ? S_EMIT : S_IDLE;
      end
      S_IDLE: begin
        if (accept_in) begin
          if (mode && (!active || blocks_left == '0)) state_next = S_EMIT;
          else state_next = S_CNT;
        end
      end
      S_CNT: begin
        alu_req    = '{op: ALU_ADD, a: AW'(cfg.file_size), b: AW'(bs_m1)};
        state_next = S_MAXC;
      end
      S_MAXC: begin
        alu_req = '{op: ALU_SUB, a: AW'(MAX_BLOCKS), b: AW'(n_r)};
        if (alu_rsp.neg || static_bad) state_next = S_EMIT;
        else state_next = item_mode ? S_FID : S_WIN;
      end
      S_WIN: begin
        alu_req    = '{op: ALU_SUB, a: AW'(n_r), b: AW'(cfg.request_window)};
        state_next = S_WPI;
      end
      S_WPI: begin
        alu_req    = '{op: ALU_SUB, a: AW'(window_left), b: AW'(1)};
        state_next = (epoch == '1) ? S_CLEAR : S_EMIT;
      end
      S_FID: begin
        alu_req    = '{op: ALU_SUB, a: AW'(item_fid), b: AW'(cfg.file_id)};
        state_next = alu_rsp.zero ? S_PAY : S_EMIT;
      end
      S_PAY: begin
        alu_req    = '{op: ALU_SUB, a: AW'(bs), b: AW'(item_payload)};
        state_next = alu_rsp.neg ? S_EMIT : S_LAST;
      end
      S_LAST: begin
        alu_req    = '{op: ALU_SUB, a: AW'(n_r), b: AW'(1)};
        state_next = S_IDX;
      end
      S_IDX: begin
        alu_req    = '{op: ALU_SUB, a: AW'(item_idx), b: AW'(last_r)};
        state_next = S_REM;
      end
      S_REM: begin
        // size of the last block
        alu_req    = '{op: ALU_SUB, a: AW'(cfg.file_size),
                       b: AW'(last_r) << cfg.block_size_log2};
        state_next = S_CLM;
      end
      S_CLM: begin
        alu_req = '{op: ALU_SUB, a: AW'(item_claimed), b: lt_r ? AW'(bs) : rem_r};
        if ((lt_r || eq_r) && alu_rsp.zero) state_next = S_WPC;
        else state_next = S_EMIT;
      end
      S_WPC: begin
        alu_req = '{op: ALU_SUB, a: AW'(window_position), b: AW'(item_idx)};
        if (wanted && item_wok) begin
          ram_we     = 1'b1;
          state_next = S_DECB;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_DECB: begin
        alu_req    = '{op: ALU_SUB, a: AW'(blocks_left), b: AW'(1)};
        state_next = S_DECW;
      end
      S_DECW: begin
        alu_req = '{op: ALU_SUB, a: AW'(window_left), b: AW'(1)};
        if (cfg.request_window != '0 && (window_left == '0 || alu_rsp.zero))
          state_next = S_MINW;
        else
          state_next = S_FIN;
      end
      S_MINW: begin
        alu_req    = '{op: ALU_SUB, a: AW'(blocks_left), b: AW'(cfg.request_window)};
        state_next = S_ADDWP;
      end
      S_ADDWP: begin
        alu_req    = '{op: ALU_ADD, a: AW'(window_position), b: AW'(window_left)};
        state_next = S_FIN;
      end
      S_FIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      blocks_left     <= '0;
      window_left     <= '0;
      window_position <= '0;
      epoch           <= EP_W'(1);
      pend            <= 1'b0;
      clear_addr      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (clear_last) begin
            clear_addr <= '0;
            epoch      <= EP_W'(1);
          end else begin
            clear_addr <= clear_addr + IW'(1);
          end
        end
        S_IDLE: begin
          if (accept_in) begin
            item_mode    <= mode;
            item_fid     <= arrived_file_id;
            item_idx     <= block_index;
            item_claimed <= claimed_size;
            item_payload <= payload_bytes;
            item_wok     <= write_ok;
            res_status   <= ST_UNEXPECTED;
            res_req      <= 1'b0;
            off_r        <= '0;
          end
        end
        S_CNT: begin
          n_r <= N_W'(alu_rsp.res >> cfg.block_size_log2);
        end
        S_MAXC: begin
          if (alu_rsp.neg || static_bad) begin
            res_status <= ST_BAD_CFG;
            if (!item_mode) begin
              active          <= 1'b0;
              blocks_left     <= '0;
              window_left     <= '0;
              window_position <= '0;
            end
          end
        end
        S_WIN: begin
          blocks_left <= BW'(n_r);
          active      <= 1'b1;
          if (cfg.request_window == '0 || alu_rsp.neg) window_left <= BW'(n_r);
          else window_left <= BW'(cfg.request_window);
        end
        S_WPI: begin
          window_position <= IW'(alu_rsp.res);
          res_status      <= ST_OK;
          res_req         <= 1'b1;
          pend            <= 1'b1;
          if (epoch != '1) epoch <= epoch + EP_W'(1);
        end
        S_FID: begin
          if (!alu_rsp.zero) res_status <= ST_WRONG_FILE;
        end
        S_LAST: begin
          last_r <= N_W'(alu_rsp.res);
        end
        S_IDX: begin
          lt_r <= alu_rsp.neg;
          eq_r <= alu_rsp.zero;
        end
        S_REM: begin
          rem_r <= alu_rsp.res;
        end
        S_CLM: begin
          res_status <= ST_RANGE;
        end
        S_WPC: begin
          if (!wanted) begin
            res_status <= ST_DUP;
          end else begin
            off_r <= off_calc;
            if (!item_wok) res_status <= ST_WRITE_ERR;
          end
        end
        S_DECB: begin
          blocks_left <= BW'(alu_rsp.res);
        end
        S_DECW: begin
          if (window_left != '0) window_left <= BW'(alu_rsp.res);
        end
        S_MINW: begin
          window_left <= alu_rsp.neg ? blocks_left : BW'(cfg.request_window);
        end
        S_ADDWP: begin
          window_position <= IW'(alu_rsp.res);
          res_req         <= (window_left != '0);
        end
        S_FIN: begin
          res_status <= (blocks_left == '0) ? ST_OK : ST_ACCEPTED;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            request_more <= res_req;
            remaining    <= REM_W'(blocks_left);
            write_offset <= off_r;
            pend         <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_window_le_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> window_left <= blocks_left)
    else $error("window count exceeds blocks left");

  a_blocks_bounded: assert property (@(posedge clk) disable iff (rst)
    blocks_left <= BW'(MAX_BLOCKS))
    else $error("blocks left above map depth");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    epoch != '0)
    else $error("epoch collides with cleared tag");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE)
    else $error("accepted item not started");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && out_free |=> out_valid)
    else $error("result not presented");

endmodule

FILE: rtl/block_receive_window_tracker.sv
// Block receive window tracker. A block outside a transfer goes straight to the result;
// starts and other blocks walk their checks one item at a time through one shared
// 32-bit ALU; the next transfer is taken the cycle after the result loads.
// After reset, and on every 255th valid start, a clearing pass sweeps all MAX_BLOCKS
// entries of the receive map; in_stall stays high during it.
// Reset (rst, synchronous) clears the transfer state and loads register defaults.
module block_receive_window_tracker import brwt_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [FID_W-1:0]  arrived_file_id,
  input  logic [IDX_W-1:0]  block_index,
  input  logic [SZ_W-1:0]   claimed_size,
  input  logic [SZ_W-1:0]   payload_bytes,
  input  logic              write_ok,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic              request_more,
  output logic [REM_W-1:0]  remaining,
  output logic [OFF_W-1:0]  write_offset
);

  localparam int IW = $clog2(MAX_BLOCKS);

  cfg_t          cfg;
  logic          cfg_wr;
  logic [1:0]    reg_idx;
  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_raddr;
  logic [EP_W-1:0] ram_wdata;
  logic [EP_W-1:0] ram_rdata;
  status_t       status_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign status  = status_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.file_id         <= FID_W'(1);
      cfg.file_size       <= FSZ_W'(1);
      cfg.block_size_log2 <= LOG_W'(10);
      cfg.request_window  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FILE_ID:   cfg.file_id         <= pwdata[FID_W-1:0];
        REG_FILE_SIZE: cfg.file_size       <= pwdata[FSZ_W-1:0];
        REG_BLK_LOG2:  cfg.block_size_log2 <= pwdata[LOG_W-1:0];
        REG_WINDOW:    cfg.request_window  <= pwdata[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FILE_ID:   prdata = DATA_W'(cfg.file_id);
      REG_FILE_SIZE: prdata = DATA_W'(cfg.file_size);
      REG_BLK_LOG2:  prdata = DATA_W'(cfg.block_size_log2);
      REG_WINDOW:    prdata = DATA_W'(cfg.request_window);
      default:       prdata = '0;
    endcase
  end

  brwt_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // receive map: epoch tag per block, a match means received this transfer
  brwt_ram #(
    .WIDTH (EP_W),
    .DEPTH (MAX_BLOCKS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  brwt_seq #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .arrived_file_id (arrived_file_id),
    .block_index     (block_index),
    .claimed_size    (claimed_size),
    .payload_bytes   (payload_bytes),
    .write_ok        (write_ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status_q),
    .request_more    (request_more),
    .remaining       (remaining),
    .write_offset    (write_offset),
    .alu_req         (alu_req),
    .alu_rsp         (alu_rsp),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

endmodule
